### rtl/ufbs_pkg.sv
// Package for the UART fractional baud search block.
// Holds widths, constants, register indexes and the controller/datapath structs.
`timescale 1ns / 1ps

package ufbs_pkg;

  localparam int BAUD_W  = 22;
  localparam int CLK_W   = 28;
  localparam int PCT_W   = 7;
  localparam int DVD_W   = 29;
  localparam int DVS_W   = 22;
  localparam int CNT_W   = 5;
  localparam int LIM_W   = 29;
  localparam int ERR_W   = 17;
  localparam int LATCH_W = 16;
  localparam int NIB_W   = 4;
  localparam int BASE_SHIFT = 6;

  localparam logic [CNT_W-1:0]   DIV_LAST  = CNT_W'(DVD_W - 1);
  localparam logic [ERR_W-1:0]   ERR_NONE  = ERR_W'(100000);
  localparam logic [PCT_W-1:0]   PCT_SCALE = PCT_W'(100);
  localparam logic [BAUD_W-1:0]  DIV_MIN   = BAUD_W'(3);
  localparam logic [NIB_W-1:0]   MUL_MAX   = NIB_W'(15);
  localparam logic [NIB_W-1:0]   ADD_MAX   = NIB_W'(15);
  localparam logic [NIB_W-1:0]   MUL_FIRST = NIB_W'(1);
  localparam logic [NIB_W-1:0]   ADD_FIRST = NIB_W'(0);

  localparam logic [CLK_W-1:0]   CORE_CLK_RST = CLK_W'(100000000);
  localparam logic [PCT_W-1:0]   ACC_ERR_RST  = PCT_W'(3);

  localparam int CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] CFG_CORE_CLK = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_ACC_ERR  = 1'b1;

  typedef enum logic [1:0] {
    OP_SCALE = 2'd0,
    OP_DV    = 2'd1,
    OP_RATE  = 2'd2
  } op_t;

  typedef struct packed {
    logic load;
    logic start;
    logic cap;
    logic eval;
    logic next;
    logic out_load;
    op_t  op;
  } cmd_t;

  typedef struct packed {
    logic div_done;
    logic baud_zero;
    logic dv_ok;
    logic zero_hit;
    logic last_pair;
  } stat_t;

endpackage

### rtl/ufbs_div.sv
// Restoring serial divider, one quotient bit per cycle.
// Depends on ufbs_pkg for widths.
`timescale 1ns / 1ps

module ufbs_div
  import ufbs_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [DVD_W-1:0] dividend,
  input  logic [DVS_W-1:0] divisor,
  output logic             done,
  output logic [DVD_W-1:0] quotient,
  output logic [DVS_W-1:0] remainder
);

  logic [DVD_W-1:0] q_r, q_nxt;
  logic [DVS_W-1:0] rem_r, rem_nxt;
  logic [DVS_W-1:0] d_r, d_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             busy_r, busy_nxt;
  logic             done_r, done_nxt;
  logic [DVS_W:0]   trial;
  logic [DVS_W:0]   diff;

  assign trial = {rem_r, q_r[DVD_W-1]};
  assign diff  = trial - {1'b0, d_r};

  always_comb begin
    q_nxt    = q_r;
    rem_nxt  = rem_r;
    d_nxt    = d_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      q_nxt    = dividend;
      rem_nxt  = '0;
      d_nxt    = divisor;
      cnt_nxt  = '0;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (trial >= {1'b0, d_r}) begin
        rem_nxt = diff[DVS_W-1:0];
        q_nxt   = {q_r[DVD_W-2:0], 1'b1};
      end else begin
        rem_nxt = trial[DVS_W-1:0];
        q_nxt   = {q_r[DVD_W-2:0], 1'b0};
      end
      cnt_nxt = cnt_r + CNT_W'(1);
      if (cnt_r == DIV_LAST) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    q_r   <= q_nxt;
    rem_r <= rem_nxt;
    d_r   <= d_nxt;
  end

  assign done      = done_r;
  assign quotient  = q_r;
  assign remainder = rem_r;

endmodule

### rtl/ufbs_dp.sv
// Datapath of the baud search: candidate pair, operands, best setting, result.
// Depends on ufbs_pkg and the shared serial divider ufbs_div.
`timescale 1ns / 1ps

module ufbs_dp
  import ufbs_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  cmd_t                cmd,
  output stat_t               stat,
  input  logic [BAUD_W-1:0]   in_baud,
  input  logic [CLK_W-1:0]    core_clock_hz,
  input  logic [PCT_W-1:0]    acc_err_pct,
  output logic                res_success,
  output logic [LATCH_W-1:0]  res_div,
  output logic [NIB_W-1:0]    res_mul,
  output logic [NIB_W-1:0]    res_add,
  output logic [ERR_W-1:0]    res_err
);

  logic [BAUD_W-1:0]  baud_r;
  logic [LIM_W-1:0]   limit_r;
  logic [NIB_W-1:0]   mul_r, add_r;
  logic [BAUD_W-1:0]  scaled_r;
  logic [LATCH_W-1:0] dv_r;
  logic [BAUD_W-1:0]  rate_r;
  logic [ERR_W-1:0]   best_err_r;
  logic [LATCH_W-1:0] best_div_r;
  logic [NIB_W-1:0]   best_mul_r, best_add_r;

  logic [BAUD_W-1:0]  base;
  logic [DVD_W-1:0]   dividend;
  logic [DVS_W-1:0]   divisor;
  logic               div_done;
  logic [DVD_W-1:0]   quot;
  logic [DVS_W-1:0]   rem;
  logic [BAUD_W-1:0]  dv_full;
  logic [BAUD_W-1:0]  err;
  logic               better;
  logic               last_pair;

  assign base = core_clock_hz[CLK_W-1:BASE_SHIFT];

  always_comb begin
    case (cmd.op)
      OP_SCALE: begin
        dividend = DVD_W'(mul_r) * DVD_W'(base);
        divisor  = DVS_W'({1'b0, mul_r} + {1'b0, add_r});
      end
      OP_DV: begin
        dividend = DVD_W'(scaled_r);
        divisor  = baud_r;
      end
      OP_RATE: begin
        dividend = DVD_W'(scaled_r);
        divisor  = DVS_W'(dv_r);
      end
      default: begin
        dividend = DVD_W'(scaled_r);
        divisor  = baud_r;
      end
    endcase
  end

  ufbs_div u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (cmd.start),
    .dividend  (dividend),
    .divisor   (divisor),
    .done      (div_done),
    .quotient  (quot),
    .remainder (rem)
  );

  // round to nearest: bump when remainder exceeds half the rate
  assign dv_full = quot[BAUD_W-1:0]
                 + BAUD_W'(rem > {1'b0, baud_r[BAUD_W-1:1]});

  assign err       = (rate_r <= baud_r) ? (baud_r - rate_r) : (rate_r - baud_r);
  assign better    = err < BAUD_W'(best_err_r);
  assign last_pair = (mul_r == MUL_MAX) && (add_r == ADD_MAX);

  assign stat.div_done  = div_done;
  assign stat.baud_zero = (baud_r == '0);
  assign stat.dv_ok     = (dv_full >= DIV_MIN) && (dv_full[BAUD_W-1:LATCH_W] == '0);
  assign stat.zero_hit  = better && (err == '0);
  assign stat.last_pair = last_pair;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      baud_r     <= in_baud;
      limit_r    <= LIM_W'(in_baud) * LIM_W'(acc_err_pct);
      mul_r      <= MUL_FIRST;
      add_r      <= ADD_FIRST;
      best_err_r <= ERR_NONE;
      best_div_r <= '0;
      best_mul_r <= MUL_FIRST;
      best_add_r <= ADD_FIRST;
    end else begin
      if (cmd.cap) begin
        case (cmd.op)
          OP_SCALE: scaled_r <= quot[BAUD_W-1:0];
          OP_DV:    dv_r     <= dv_full[LATCH_W-1:0];
          OP_RATE:  rate_r   <= quot[BAUD_W-1:0];
          default:  rate_r   <= quot[BAUD_W-1:0];
        endcase
      end
      if (cmd.eval && better) begin
        best_err_r <= err[ERR_W-1:0];
        best_div_r <= dv_r;
        best_mul_r <= mul_r;
        best_add_r <= add_r;
      end
      if (cmd.next) begin
        if (add_r == ADD_MAX) begin
          add_r <= ADD_FIRST;
          mul_r <= mul_r + NIB_W'(1);
        end else begin
          add_r <= add_r + NIB_W'(1);
        end
      end
    end
    // error below baud * percent / 100 (truncated) holds when (error + 1) * 100 fits under baud * percent
    if (cmd.out_load) begin
      res_success <= (best_div_r != '0)
                  && ((LIM_W'(best_err_r) + LIM_W'(1)) * LIM_W'(PCT_SCALE) <= limit_r);
      res_div     <= best_div_r;
      res_mul     <= best_mul_r;
      res_add     <= best_add_r;
      res_err     <= best_err_r;
    end
  end

endmodule

### rtl/ufbs_ctrl.sv
// Sequencer of the baud search: issues divider operations and pair steps.
// Depends on ufbs_pkg for the command and status structs.
`timescale 1ns / 1ps

module ufbs_ctrl
  import ufbs_pkg::*;
(
  input  logic  clk,
  input  logic  rst_n,
  input  logic  in_valid,
  output logic  in_ready,
  output logic  out_valid,
  input  logic  out_ready,
  input  stat_t stat,
  output cmd_t  cmd
);

  typedef enum logic [8:0] {
    S_IDLE    = 9'b000000001,
    S_SCL_GO  = 9'b000000010,
    S_SCL_W   = 9'b000000100,
    S_DV_GO   = 9'b000001000,
    S_DV_W    = 9'b000010000,
    S_RATE_GO = 9'b000100000,
    S_RATE_W  = 9'b001000000,
    S_EVAL    = 9'b010000000,
    S_FIN     = 9'b100000000
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;

  always_comb begin
    state_nxt    = state_r;
    cmd          = '0;
    cmd.op       = OP_SCALE;
    in_ready     = 1'b0;
    out_valid_nxt = out_valid_r && !out_ready;
    case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = S_SCL_GO;
        end
      end
      S_SCL_GO: begin
        cmd.op = OP_SCALE;
        if (stat.baud_zero) begin
          state_nxt = S_FIN;
        end else begin
          cmd.start = 1'b1;
          state_nxt = S_SCL_W;
        end
      end
      S_SCL_W: begin
        cmd.op  = OP_SCALE;
        cmd.cap = stat.div_done;
        if (stat.div_done) begin
          state_nxt = S_DV_GO;
        end
      end
      S_DV_GO: begin
        cmd.op    = OP_DV;
        cmd.start = 1'b1;
        state_nxt = S_DV_W;
      end
      S_DV_W: begin
        cmd.op  = OP_DV;
        cmd.cap = stat.div_done;
        if (stat.div_done) begin
          if (stat.dv_ok) begin
            state_nxt = S_RATE_GO;
          end else begin
            cmd.next  = 1'b1;
            state_nxt = stat.last_pair ? S_FIN : S_SCL_GO;
          end
        end
      end
      S_RATE_GO: begin
        cmd.op    = OP_RATE;
        cmd.start = 1'b1;
        state_nxt = S_RATE_W;
      end
      S_RATE_W: begin
        cmd.op  = OP_RATE;
        cmd.cap = stat.div_done;
        if (stat.div_done) begin
          state_nxt = S_EVAL;
        end
      end
      S_EVAL: begin
        cmd.eval  = 1'b1;
        cmd.next  = 1'b1;
        state_nxt = (stat.zero_hit || stat.last_pair) ? S_FIN : S_SCL_GO;
      end
      S_FIN: begin
        if (!out_valid_r || out_ready) begin
          cmd.out_load  = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

endmodule

### rtl/uart_fractional_baud_search.sv
// Top level of the UART fractional baud-rate divider search.
// Depends on ufbs_pkg, ufbs_ctrl, ufbs_dp and ufbs_div.
//
// Usage:
//   Write core_clock_hz (index 0) and accepted_error_percent (index 1) on the
//   cfg_ port while no request is in flight. A request carries in_requested_baud
//   over a valid/ready channel; in_ready is high only while the search is idle.
//   The search walks multiplier 1..15 and add value 0..15, stopping early at
//   zero error. Each pair runs up to three serial divisions on one shared
//   divider, each a start, 29 quotient bits and a capture, plus an
//   evaluation step; only two divisions and no evaluation run when the
//   divisor is out of range. At worst all 240 pairs are walked; a zero rate
//   goes straight to the result. A new request is taken only once the search
//   is idle again; the divider, one quotient bit per cycle, sets the pace.
//   The result sits in an output register with out_valid; a new request is
//   taken while it waits. If the receiver stalls, the next finished result
//   holds in the search until the output register is taken.
//   Reset (rst_n low, synchronous) returns the sequencer to idle, drops any
//   pending result and restores the register reset values.
`timescale 1ns / 1ps

module uart_fractional_baud_search
  import ufbs_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CLK_W-1:0]     cfg_data,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [BAUD_W-1:0]    in_requested_baud,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic                 out_success,
  output logic [LATCH_W-1:0]   out_divisor_latch,
  output logic [NIB_W-1:0]     out_mul_val,
  output logic [NIB_W-1:0]     out_div_add_val,
  output logic [2*NIB_W-1:0]   out_fraction_byte,
  output logic [ERR_W-1:0]     out_baud_error
);

  logic [CLK_W-1:0] core_clock_r;
  logic [PCT_W-1:0] acc_err_r;
  cmd_t             cmd;
  stat_t            stat;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      core_clock_r <= CORE_CLK_RST;
      acc_err_r    <= ACC_ERR_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_CORE_CLK: core_clock_r <= cfg_data;
        CFG_ACC_ERR:  acc_err_r    <= cfg_data[PCT_W-1:0];
        default:      acc_err_r    <= acc_err_r;
      endcase
    end
  end

  ufbs_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  ufbs_dp u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd           (cmd),
    .stat          (stat),
    .in_baud       (in_requested_baud),
    .core_clock_hz (core_clock_r),
    .acc_err_pct   (acc_err_r),
    .res_success   (out_success),
    .res_div       (out_divisor_latch),
    .res_mul       (out_mul_val),
    .res_add       (out_div_add_val),
    .res_err       (out_baud_error)
  );

  assign out_fraction_byte = {out_mul_val, out_div_add_val};

endmodule

### sim/uart_fractional_baud_search_tb.sv
// Testbench for uart_fractional_baud_search: directed table, then random phases.
// Predicts every search result in place and checks it field by field.
// Depends on ufbs_pkg and the block's RTL.
`timescale 1ns / 1ps

module uart_fractional_baud_search_tb
  import ufbs_pkg::*;
();

  localparam int          HALF_PERIOD   = 4;
  localparam int          SETTLE_CYCLES = 8;
  localparam int          TAIL_CYCLES   = 60;
  localparam longint      LIMIT_CYCLES  = 12_000_000;
  localparam logic [63:0] DIV_LIMIT     = 64'd65536;
  localparam int          PHASES        = 6;
  localparam int          PHASE_ITEMS   = 13;

  typedef struct packed {
    logic               success;
    logic [LATCH_W-1:0] divisor;
    logic [NIB_W-1:0]   mul_val;
    logic [NIB_W-1:0]   add_val;
    logic [2*NIB_W-1:0] frac;
    logic [ERR_W-1:0]   err;
  } fit_t;

  typedef struct packed {
    logic [CLK_W-1:0]  hz;
    logic [PCT_W-1:0]  pct;
    logic [BAUD_W-1:0] baud;
    logic              typed;
    fit_t              fit;
  } row_t;

  localparam fit_t NO_FIT   = '{1'b0, 16'd0, 4'd1, 4'd0, 8'h10, ERR_NONE};
  localparam fit_t EXACT_16 = '{1'b1, 16'd16, 4'd1, 4'd0, 8'h10, 17'd0};
  localparam int   ROWS     = 22;

  row_t plan [ROWS] = '{
    '{28'd100000000, 7'd3,   22'd0,       1'b1, NO_FIT},
    '{28'd100000000, 7'd3,   22'd1,       1'b1, NO_FIT},
    '{28'd100000000, 7'd3,   22'h3FFFFF,  1'b1, NO_FIT},
    '{28'd100000000, 7'd3,   22'd9600,    1'b0, '0},
    '{28'd100000000, 7'd3,   22'd115200,  1'b0, '0},
    '{28'd100000000, 7'd3,   22'd520833,  1'b0, '0},
    '{28'd100000000, 7'd3,   22'h2AAAAA,  1'b0, '0},
    '{28'd100000000, 7'd3,   22'h155555,  1'b0, '0},
    '{28'd100000000, 7'd3,   22'd300,     1'b0, '0},
    '{28'd117964800, 7'd3,   22'd115200,  1'b1, EXACT_16},
    '{28'd117964800, 7'd3,   22'd4000000, 1'b0, '0},
    '{28'd63,        7'd3,   22'd9600,    1'b1, NO_FIT},
    '{28'd16,        7'd3,   22'd1,       1'b1, NO_FIT},
    '{28'd64,        7'd3,   22'd1,       1'b0, '0},
    '{28'd16000,     7'd3,   22'd2,       1'b0, '0},
    '{28'd200000000, 7'd0,   22'd9600,    1'b0, '0},
    '{28'd200000000, 7'd100, 22'd19200,   1'b0, '0},
    '{28'd200000000, 7'd100, 22'd4000000, 1'b0, '0},
    '{28'hFFFFFFF,   7'd127, 22'd0,       1'b1, NO_FIT},
    '{28'hFFFFFFF,   7'd127, 22'd1200000, 1'b0, '0},
    '{28'hFFFFFFF,   7'd127, 22'd115200,  1'b0, '0},
    '{28'hFFFFFFF,   7'd1,   22'd57600,   1'b0, '0}
  };

  int unsigned std_rates [12] = '{300, 1200, 2400, 4800, 9600, 19200, 38400,
                                  57600, 115200, 230400, 460800, 921600};

  logic                 clk;
  logic                 rst_n;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CLK_W-1:0]     cfg_data;
  logic                 in_valid;
  logic                 in_ready;
  logic [BAUD_W-1:0]    in_requested_baud;
  logic                 out_valid;
  logic                 out_ready;
  logic                 out_success;
  logic [LATCH_W-1:0]   out_divisor_latch;
  logic [NIB_W-1:0]     out_mul_val;
  logic [NIB_W-1:0]     out_div_add_val;
  logic [2*NIB_W-1:0]   out_fraction_byte;
  logic [ERR_W-1:0]     out_baud_error;

  logic [CLK_W-1:0] core_hz;
  logic [PCT_W-1:0] err_pct;
  fit_t             pending_fits [$];
  bit               gaps_on;
  int               fails;
  int               requests;
  int               checked;
  int               hits;
  int               settings;
  longint           cycles;

  uart_fractional_baud_search dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_we            (cfg_we),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_requested_baud (in_requested_baud),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_success       (out_success),
    .out_divisor_latch (out_divisor_latch),
    .out_mul_val       (out_mul_val),
    .out_div_add_val   (out_div_add_val),
    .out_fraction_byte (out_fraction_byte),
    .out_baud_error    (out_baud_error)
  );

  initial clk = 1'b0;
  always #HALF_PERIOD clk = ~clk;

  always @(posedge clk) begin
    cycles++;
    if (cycles >= LIMIT_CYCLES) begin
      $display("TIMEOUT after %0d cycles, %0d results outstanding", cycles,
               pending_fits.size());
      $display("Some tests failed");
      $finish;
    end
  end

  function automatic fit_t search_best_pair(logic [BAUD_W-1:0] baud);
    logic [63:0]        base;
    logic [63:0]        scaled;
    logic [63:0]        dv;
    logic [63:0]        rate;
    logic [63:0]        gap;
    logic [63:0]        best_gap;
    logic [63:0]        limit;
    logic [LATCH_W-1:0] best_div;
    logic [NIB_W-1:0]   best_mul;
    logic [NIB_W-1:0]   best_add;
    bit                 found;
    bit                 done;
    int                 m;
    int                 a;
    fit_t               fit;
    base     = (64'(core_hz) / 64'd4) >> 4;
    best_gap = 64'(ERR_NONE);
    best_div = '0;
    best_mul = MUL_FIRST;
    best_add = ADD_FIRST;
    found    = 1'b0;
    done     = 1'b0;
    if (baud != '0) begin
      for (m = 1; m <= MUL_MAX && !done; m++) begin
        for (a = 0; a <= ADD_MAX && !done; a++) begin
          scaled = (64'(m) * base) / 64'(m + a);
          dv     = scaled / 64'(baud);
          if (scaled % 64'(baud) > 64'(baud) / 64'd2) dv++;
          if (dv >= 64'(DIV_MIN) && dv < DIV_LIMIT) begin
            rate = scaled / dv;
            gap  = (rate <= 64'(baud)) ? 64'(baud) - rate : rate - 64'(baud);
            if (gap < best_gap) begin
              best_gap = gap;
              best_div = dv[LATCH_W-1:0];
              best_mul = m[NIB_W-1:0];
              best_add = a[NIB_W-1:0];
              found    = 1'b1;
              if (gap == 64'd0) done = 1'b1;
            end
          end
        end
      end
    end
    limit       = (64'(baud) * 64'(err_pct)) / 64'(PCT_SCALE);
    fit.success = found && (best_gap < limit);
    fit.divisor = best_div;
    fit.mul_val = best_mul;
    fit.add_val = best_add;
    fit.frac    = {best_mul, best_add};
    fit.err     = best_gap[ERR_W-1:0];
    return fit;
  endfunction

  task automatic report_mismatch(string msg);
    fails++;
    $display("MISMATCH at %0t ns: %s", $time, msg);
  endtask

  task automatic check_field(string name, longint got, longint want, longint idx);
    if (got != want)
      report_mismatch($sformatf("%s got %0d expected %0d (result %0d)", name, got, want,
                                idx));
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CLK_W-1:0] data);
    cfg_we    = 1'b1;
    cfg_index = idx;
    cfg_data  = data;
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  // hold off the sender until the search has gone quiet
  task automatic wait_idle();
    in_valid = 1'b0;
    while (pending_fits.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic apply_setting(logic [CLK_W-1:0] hz, logic [PCT_W-1:0] pct);
    wait_idle();
    write_reg(CFG_CORE_CLK, hz);
    write_reg(CFG_ACC_ERR, CLK_W'(pct));
    core_hz = hz;
    err_pct = pct;
    settings++;
  endtask

  task automatic send_request(logic [BAUD_W-1:0] baud, logic typed, fit_t fit);
    int gap;
    gap = gaps_on ? $urandom_range(0, 9) : 0;
    if (gap != 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid          = 1'b1;
    in_requested_baud = baud;
    do @(posedge clk); while (!in_ready);
    pending_fits.push_back(typed ? fit : search_best_pair(baud));
    requests++;
    @(negedge clk);
  endtask

  function automatic logic [BAUD_W-1:0] pick_baud();
    logic [63:0] base;
    int unsigned span;
    int unsigned pick;
    base = (64'(core_hz) / 64'd4) >> 4;
    pick = $urandom_range(0, 9);
    if (pick < 5) return BAUD_W'(std_rates[$urandom_range(0, 11)]);
    if (pick < 8 && base >= 64'd3) begin
      // aim near base / divisor so the search lands on valid pairs
      span = (base > 64'd65535) ? 65535 : int'(base);
      return BAUD_W'(base / 64'($urandom_range(3, span)));
    end
    return BAUD_W'($urandom_range(1, (1 << BAUD_W) - 1));
  endfunction

  // result side: stall a drawn number of cycles once a result shows
  initial begin
    fit_t want;
    int   stall;
    out_ready = 1'b0;
    @(posedge rst_n);
    @(negedge clk);
    forever begin
      stall = gaps_on ? $urandom_range(0, 9) : 0;
      if (stall == 0) begin
        out_ready = 1'b1;
        do @(posedge clk); while (!out_valid);
      end else begin
        out_ready = 1'b0;
        do @(posedge clk); while (!out_valid);
        repeat (stall) @(negedge clk);
        out_ready = 1'b1;
        do @(posedge clk); while (!out_valid);
      end
      if (pending_fits.size() == 0) begin
        report_mismatch($sformatf("result with no request pending, divisor %0d",
                                  out_divisor_latch));
      end else begin
        want = pending_fits.pop_front();
        check_field("success", out_success, want.success, checked);
        check_field("divisor_latch", out_divisor_latch, want.divisor, checked);
        check_field("mul_val", out_mul_val, want.mul_val, checked);
        check_field("div_add_val", out_div_add_val, want.add_val, checked);
        check_field("fraction_byte", out_fraction_byte, want.frac, checked);
        check_field("baud_error", out_baud_error, want.err, checked);
        if (out_success) hits++;
        checked++;
      end
      @(negedge clk);
    end
  end

  initial begin
    logic [CLK_W-1:0] hz;
    logic [PCT_W-1:0] pct;
    rst_n             = 1'b0;
    cfg_we            = 1'b0;
    cfg_index         = CFG_CORE_CLK;
    cfg_data          = '0;
    in_valid          = 1'b0;
    in_requested_baud = '0;
    core_hz           = CORE_CLK_RST;
    err_pct           = ACC_ERR_RST;
    gaps_on           = 1'b1;
    repeat (3) @(negedge clk);
    rst_n = 1'b1;

    for (int i = 0; i < ROWS; i++) begin
      if (plan[i].hz != core_hz || plan[i].pct != err_pct)
        apply_setting(plan[i].hz, plan[i].pct);
      send_request(plan[i].baud, plan[i].typed, plan[i].fit);
    end

    for (int p = 0; p < PHASES; p++) begin
      case (p)
        1: begin
          hz  = 28'hFFFFFFF;
          pct = 7'd127;
        end
        3: begin
          hz  = CLK_W'($urandom_range(16, 4000));
          pct = 7'd0;
        end
        default: begin
          hz  = CLK_W'($urandom_range(1000000, 200000000));
          pct = ($urandom_range(0, 1) == 0) ? PCT_W'($urandom_range(0, 10))
                                            : PCT_W'($urandom_range(0, 127));
        end
      endcase
      apply_setting(hz, pct);
      gaps_on = (p != 2);
      for (int k = 0; k < PHASE_ITEMS; k++)
        send_request(pick_baud(), 1'b0, '0);
    end

    in_valid = 1'b0;
    while (pending_fits.size() != 0) @(negedge clk);
    repeat (TAIL_CYCLES) @(negedge clk);

    $display("Ran %0d baud searches across %0d clock/limit settings in %0d cycles.",
             requests, settings, cycles);
    $display("Checked %0d results, %0d within the error limit, %0d mismatches.",
             checked, hits, fails);
    if (fails == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
